[rtl/core/srpt_pkg.sv]
// Package for the shortest-remaining-size flow scheduler.
// Holds the shared types and constants of srpt_cell and srpt_flow_scheduler.
// It depends on nothing else.
package srpt_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int BYTES_WIDTH = 32;
   localparam int TIME_WIDTH = 32;
   localparam int RATE_WIDTH = 16;
   localparam int PROD_WIDTH = TIME_WIDTH + RATE_WIDTH;
   localparam int SUM_WIDTH = 64;

   localparam logic ACTION_ARRIVAL = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Operation that the cells of the chain apply; a head charge reaches cell 0 only.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_HEAD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_INSERT,
      ST_RESP
   } state_type;

   // Broadcast from the controller to the cells.
   typedef struct packed {
      cell_op_type            op;
      logic [BYTES_WIDTH-1:0] size;
      logic [TIME_WIDTH-1:0]  born;
      logic [BYTES_WIDTH-1:0] head_left;
   } cell_ctrl_type;

endpackage

[rtl/core/srpt_cell.sv]
// One cell of the sorted flow chain: remaining size and creation time of one flow.
// Depends on srpt_pkg for the cell operation and the broadcast control struct.
module srpt_cell (
   input  logic                             clock,
   input  srpt_pkg::cell_ctrl_type          ctrl,
   input  logic                             live,
   input  logic                             prev_stay,
   input  logic [srpt_pkg::BYTES_WIDTH-1:0] prev_left,
   input  logic [srpt_pkg::TIME_WIDTH-1:0]  prev_born,
   input  logic [srpt_pkg::BYTES_WIDTH-1:0] next_left,
   input  logic [srpt_pkg::TIME_WIDTH-1:0]  next_born,
   output logic                             stay,
   output logic [srpt_pkg::BYTES_WIDTH-1:0] left,
   output logic [srpt_pkg::TIME_WIDTH-1:0]  born
);
   import srpt_pkg::*;

   logic [BYTES_WIDTH-1:0] left_ff, left_in;
   logic [TIME_WIDTH-1:0]  born_ff, born_in;

   // A held flow no larger than the newcomer keeps its place, so ties go to
   // the earlier entry.
   assign stay = live && (left_ff <= ctrl.size);

   always_comb begin
      left_in = left_ff;
      born_in = born_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_HEAD: begin
            left_in = ctrl.head_left;
         end
         CELL_INSERT: begin
            if (stay) begin
            end else if (prev_stay) begin
               left_in = ctrl.size;
               born_in = ctrl.born;
            end else begin
               left_in = prev_left;
               born_in = prev_born;
            end
         end
         CELL_POP: begin
            left_in = next_left;
            born_in = next_born;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      born_ff <= born_in;
   end

   assign left = left_ff;
   assign born = born_ff;

endmodule

[rtl/core/srpt_flow_scheduler.sv]
// Top level of the shortest-remaining-size flow scheduler: controller and cell chain.
// Depends on srpt_pkg and instantiates srpt_cell once per queue entry.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    action, now, flow_bytes, born_at
//   rsp_      out        rsp_valid/rsp_ready    finished, completion_span, span_total,
//                                               done_total, waiting, dropped
//   csr_      in         csr_write_enable       link_rate (16 bit)
//
// An item's result passes through the elapsed-time multiply, the head charge or pop, the
// chain insert (for an inserting arrival only) and the result load, in that order, and no new
// item is accepted until the result is loaded into the output register.
// A result that is not taken holds the sequencer in its last step.
// Reset is synchronous and clears the flow count, the timers and the totals; the
// cell contents are not cleared because only live cells are ever read.
module srpt_flow_scheduler #(
   parameter int QUEUE_DEPTH = srpt_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [srpt_pkg::TIME_WIDTH-1:0]  req_now,
   input  logic [srpt_pkg::BYTES_WIDTH-1:0] req_flow_bytes,
   input  logic [srpt_pkg::TIME_WIDTH-1:0]  req_born_at,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_finished,
   output logic [srpt_pkg::TIME_WIDTH-1:0]  rsp_completion_span,
   output logic [srpt_pkg::SUM_WIDTH-1:0]   rsp_span_total,
   output logic [31:0]                      rsp_done_total,
   output logic [COUNT_WIDTH-1:0]           rsp_waiting,
   output logic                             rsp_dropped,
   input  logic                             csr_write_enable,
   input  logic [srpt_pkg::RATE_WIDTH-1:0]  csr_write_data
);
   import srpt_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   // Sequencer state.
   state_type state_ff, state_in;

   // The item being worked on.
   logic                   act_ff, act_in;
   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic [BYTES_WIDTH-1:0] size_ff, size_in;
   logic [TIME_WIDTH-1:0]  born_ff, born_in;
   logic [TIME_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic [PROD_WIDTH-1:0]  prod_ff, prod_in;

   // Scheduler state.
   logic [RATE_WIDTH-1:0]  rate_ff, rate_in;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [31:0]            done_ff, done_in;

   // Result of the current item, before it reaches the output register.
   logic                   res_finished_ff, res_finished_in;
   logic [TIME_WIDTH-1:0]  res_span_ff, res_span_in;
   logic                   res_dropped_ff, res_dropped_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_finished_ff, rsp_finished_in;
   logic [TIME_WIDTH-1:0]  rsp_span_ff, rsp_span_in;
   logic [SUM_WIDTH-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [31:0]            rsp_done_ff, rsp_done_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;

   // Chain wiring.
   cell_ctrl_type          chain_ctrl;
   cell_op_type            cell_op;
   logic [BYTES_WIDTH-1:0] head_left;
   logic [BYTES_WIDTH-1:0] cell_left [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]  cell_born [QUEUE_DEPTH];
   logic                   cell_stay [QUEUE_DEPTH];

   logic                   accept;
   logic                   rsp_load;
   logic                   covered;
   logic [TIME_WIDTH-1:0]  head_span;

   assign accept = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // The head completes once its service covers what it has left; an arrival
   // charges it the same service, but never below one byte.
   assign covered = prod_ff >= PROD_WIDTH'(cell_left[0]);
   assign head_left = covered ? BYTES_WIDTH'(1) : cell_left[0] - prod_ff[BYTES_WIDTH-1:0];
   assign head_span = now_ff - cell_born[0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (act_ff == ACTION_ARRIVAL && count_ff != FULL_COUNT) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_INSERT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer and the datapath updates.
   always_comb begin
      req_ready = 1'b0;
      cell_op = CELL_HOLD;
      act_in = act_ff;
      now_in = now_ff;
      size_in = size_ff;
      born_in = born_ff;
      elapsed_in = elapsed_ff;
      prod_in = prod_ff;
      start_in = start_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      done_in = done_ff;
      res_finished_in = res_finished_ff;
      res_span_in = res_span_ff;
      res_dropped_in = res_dropped_ff;
      rsp_finished_in = rsp_finished_ff;
      rsp_span_in = rsp_span_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_done_in = rsp_done_ff;
      rsp_count_in = rsp_count_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rate_in = csr_write_enable ? csr_write_data : rate_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               act_in = req_action;
               now_in = req_now;
               size_in = req_flow_bytes;
               born_in = req_born_at;
               // Time running backwards counts as no service at all.
               elapsed_in = (req_now >= start_ff) ? (req_now - start_ff) : '0;
            end
         end
         ST_MUL: begin
            prod_in = PROD_WIDTH'(elapsed_ff) * PROD_WIDTH'(rate_ff);
         end
         ST_EVAL: begin
            res_finished_in = 1'b0;
            res_span_in = '0;
            res_dropped_in = 1'b0;
            if (act_ff == ACTION_ARRIVAL) begin
               if (count_ff == FULL_COUNT) begin
                  res_dropped_in = 1'b1;
               end else if (count_ff != '0) begin
                  cell_op = CELL_HEAD;
               end
            end else if (count_ff != '0 && covered) begin
               cell_op = CELL_POP;
               res_finished_in = 1'b1;
               res_span_in = head_span;
               sum_in = sum_ff + SUM_WIDTH'(head_span);
               done_in = done_ff + 32'd1;
               count_in = count_ff - COUNT_WIDTH'(1);
               start_in = now_ff;
            end
         end
         ST_INSERT: begin
            cell_op = CELL_INSERT;
            count_in = count_ff + COUNT_WIDTH'(1);
            start_in = now_ff;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_finished_in = res_finished_ff;
               rsp_span_in = res_span_ff;
               rsp_sum_in = sum_ff;
               rsp_done_in = done_ff;
               rsp_count_in = count_ff;
               rsp_dropped_in = res_dropped_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff <= RATE_WIDTH'(1);
         start_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rate_ff <= rate_in;
         start_ff <= start_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      now_ff <= now_in;
      size_ff <= size_in;
      born_ff <= born_in;
      elapsed_ff <= elapsed_in;
      prod_ff <= prod_in;
      res_finished_ff <= res_finished_in;
      res_span_ff <= res_span_in;
      res_dropped_ff <= res_dropped_in;
      rsp_finished_ff <= rsp_finished_in;
      rsp_span_ff <= rsp_span_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_done_ff <= rsp_done_in;
      rsp_count_ff <= rsp_count_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   // The newcomer and the charged head value are broadcast to the whole chain.
   assign chain_ctrl.op = cell_op;
   assign chain_ctrl.size = size_ff;
   assign chain_ctrl.born = born_ff;
   assign chain_ctrl.head_left = head_left;

   // The cell chain. Cell 0 is the head; only it takes the charged value, and
   // each inner cell exchanges its contents with its two neighbors, the end cells with one.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type          ctrl_i;
      logic                   prev_stay_i;
      logic [BYTES_WIDTH-1:0] prev_left_i, next_left_i;
      logic [TIME_WIDTH-1:0]  prev_born_i, next_born_i;

      always_comb begin
         ctrl_i = chain_ctrl;
         if (i != 0 && chain_ctrl.op == CELL_HEAD) begin
            ctrl_i.op = CELL_HOLD;
         end
      end

      if (i == 0) begin : g_first
         assign prev_stay_i = 1'b1;
         assign prev_left_i = '0;
         assign prev_born_i = '0;
      end else begin : g_inner
         assign prev_stay_i = cell_stay[i-1];
         assign prev_left_i = cell_left[i-1];
         assign prev_born_i = cell_born[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_left_i = cell_left[i];
         assign next_born_i = cell_born[i];
      end else begin : g_body
         assign next_left_i = cell_left[i+1];
         assign next_born_i = cell_born[i+1];
      end

      srpt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl_i),
         .live      (count_ff > COUNT_WIDTH'(i)),
         .prev_stay (prev_stay_i),
         .prev_left (prev_left_i),
         .prev_born (prev_born_i),
         .next_left (next_left_i),
         .next_born (next_born_i),
         .stay      (cell_stay[i]),
         .left      (cell_left[i]),
         .born      (cell_born[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_finished = rsp_finished_ff;
   assign rsp_completion_span = rsp_span_ff;
   assign rsp_span_total = rsp_sum_ff;
   assign rsp_done_total = rsp_done_ff;
   assign rsp_waiting = rsp_count_ff;
   assign rsp_dropped = rsp_dropped_ff;

   // The flow count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("flow count above queue depth");

   // A dropped arrival leaves the flow count alone.
   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && act_ff == ACTION_ARRIVAL && count_ff == FULL_COUNT)
      |=> $stable(count_ff))
      else $error("drop changed the flow count");

   // The chain stays sorted between items: the head is never larger than the next.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff >= COUNT_WIDTH'(2)) |-> cell_left[0] <= cell_left[1])
      else $error("cell chain out of order");

   // A pop only happens with a flow present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cell_op == CELL_POP) |-> count_ff != '0)
      else $error("pop on an empty chain");

endmodule
